@@ src/lsdr_pkg.sv @@
package lsdr_pkg;

  localparam int MAX_RECORDS_DEF = 64;
  localparam int KEY_W           = 16;
  localparam int TAG_W           = 6;
  localparam int RADIX           = 10;
  localparam int DIG_W           = 4;

  // controller state, one-hot
  typedef enum logic [7:0] {
    ST_LOAD  = 8'b00000001,
    ST_CLR   = 8'b00000010,
    ST_COUNT = 8'b00000100,
    ST_PSUM  = 8'b00001000,
    ST_PLACE = 8'b00010000,
    ST_GAP   = 8'b00100000,
    ST_COPY  = 8'b01000000,
    ST_EMIT  = 8'b10000000
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;       // store incoming word
    logic clr_cnt;    // zero digit counters
    logic count;      // count digit of record at index
    logic psum;       // one running-sum step over the counters
    logic place;      // scatter record at index (descending)
    logic copy;       // copy pass store back
    logic next_w;     // advance digit weight
    logic emit;       // read record at index for output
    logic done_set;   // clear set state
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic more_pass;  // largest key / weight > 0
    logic empty;      // no stored records
  } sts_t;

endpackage

@@ src/lsdr_datapath.sv @@
module lsdr_datapath #(
  parameter int MAX_RECORDS = lsdr_pkg::MAX_RECORDS_DEF,
  localparam int IDX_W = $clog2(MAX_RECORDS),
  localparam int CNT_W = $clog2(MAX_RECORDS + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lsdr_pkg::cmd_t           cmd,
  input  logic [IDX_W-1:0]         idx,
  input  logic [lsdr_pkg::KEY_W-1:0] in_key,
  input  logic [lsdr_pkg::TAG_W-1:0] in_tag,
  output lsdr_pkg::sts_t           sts,
  output logic [CNT_W-1:0]         fill_cnt,
  output logic                     dropped,
  output logic [lsdr_pkg::KEY_W-1:0] rd_key,
  output logic [lsdr_pkg::TAG_W-1:0] rd_tag
);
  localparam int KW = lsdr_pkg::KEY_W;
  localparam int DW = lsdr_pkg::DIG_W;
  localparam int RW = lsdr_pkg::TAG_W + 2 * KW;

  // record layout: {tag, key, key / current weight}
  logic [RW-1:0] rec_mem [MAX_RECORDS];
  logic [RW-1:0] pas_mem [MAX_RECORDS];
  logic [CNT_W-1:0] cnt_r [lsdr_pkg::RADIX];
  logic [CNT_W-1:0] fill_r;
  logic dropped_r;
  // largest key / weight, divided by 10 after each pass
  logic [KW-1:0] quo_r;
  logic [RW-1:0] rec_q, pas_q;
  // record commands are registered and act in the cycle after issue, on the registered read data
  logic [IDX_W-1:0] idx_d;
  logic count_d, psum_d, place_d, copy_d;
  logic [DW-1:0] ps_r;
  logic [KW-1:0] rem_q;
  logic [KW-1:0] rem_div;
  logic [DW-1:0] dig;
  logic [CNT_W-1:0] pos;

  // x / 10 by reciprocal multiply, exact for 16-bit x
  function automatic logic [KW-1:0] div10(input logic [KW-1:0] x);
    logic [31:0] p;
    p = 32'(x) * 32'd52429;
    return KW'(p[31:19]);
  endfunction

  // low decimal digit of the remaining key: rem - 10 * (rem / 10)
  assign rem_q   = rec_q[KW-1:0];
  assign rem_div = div10(rem_q);
  assign dig     = DW'(rem_q - (rem_div << 3) - (rem_div << 1));
  assign pos     = cnt_r[dig] - CNT_W'(1);

  // record store: load or copy-back write, registered read
  always_ff @(posedge clk) begin
    if (cmd.load && fill_r < CNT_W'(MAX_RECORDS))
      rec_mem[fill_r[IDX_W-1:0]] <= {in_tag, in_key, in_key};
    else if (copy_d)
      rec_mem[idx_d] <= pas_q;
    rec_q <= rec_mem[idx];
  end

  // pass store: scatter write with next digit's remainder, registered read
  always_ff @(posedge clk) begin
    if (place_d)
      pas_mem[pos[IDX_W-1:0]] <= {rec_q[RW-1:KW], rem_div};
    pas_q <= pas_mem[idx];
  end

  // command delay to line up with read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_d <= 1'b0;
      psum_d  <= 1'b0;
      place_d <= 1'b0;
      copy_d  <= 1'b0;
    end else begin
      count_d <= cmd.count;
      psum_d  <= cmd.psum;
      place_d <= cmd.place;
      copy_d  <= cmd.copy;
    end
    idx_d <= idx;
  end

  // counters and set state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      dropped_r <= 1'b0;
      quo_r     <= '0;
      ps_r      <= DW'(1);
      for (int i = 0; i < lsdr_pkg::RADIX; i++) cnt_r[i] <= '0;
    end else begin
      if (cmd.load) begin
        if (fill_r < CNT_W'(MAX_RECORDS)) begin
          fill_r <= fill_r + CNT_W'(1);
          if (in_key > quo_r) quo_r <= in_key;
        end else begin
          dropped_r <= 1'b1;
        end
      end
      if (cmd.clr_cnt) begin
        for (int i = 0; i < lsdr_pkg::RADIX; i++) cnt_r[i] <= '0;
        ps_r <= DW'(1);
      end
      if (count_d) cnt_r[dig] <= cnt_r[dig] + CNT_W'(1);
      if (psum_d) begin
        cnt_r[ps_r] <= cnt_r[ps_r] + cnt_r[ps_r - DW'(1)];
        ps_r <= ps_r + DW'(1);
      end
      if (place_d) cnt_r[dig] <= pos;
      if (cmd.next_w) quo_r <= div10(quo_r);
      if (cmd.done_set) begin
        fill_r    <= '0;
        dropped_r <= 1'b0;
        quo_r     <= '0;
      end
    end
  end

  assign sts.more_pass = (quo_r != '0);
  assign sts.empty     = (fill_r == '0);
  assign fill_cnt = fill_r;
  assign dropped  = dropped_r;
  assign rd_key = rec_q[RW-lsdr_pkg::TAG_W-1:KW];
  assign rd_tag = rec_q[RW-1:RW-lsdr_pkg::TAG_W];
endmodule

@@ src/lsdr_ctrl.sv @@
module lsdr_ctrl #(
  parameter int MAX_RECORDS = lsdr_pkg::MAX_RECORDS_DEF,
  localparam int IDX_W = $clog2(MAX_RECORDS),
  localparam int CNT_W = $clog2(MAX_RECORDS + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             final_item,
  input  lsdr_pkg::sts_t   sts,
  input  logic [CNT_W-1:0] fill_cnt,
  output lsdr_pkg::cmd_t   cmd,
  output logic [IDX_W-1:0] idx,
  output logic             busy,
  output logic             emit_v,
  output logic             emit_last
);
  localparam int DW = lsdr_pkg::DIG_W;

  lsdr_pkg::state_t st_r, st_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [DW-1:0] d_r, d_nxt;  // running-sum step

  assign idx  = i_r[IDX_W-1:0];
  assign busy = (st_r != lsdr_pkg::ST_LOAD);

  always_comb begin
    st_nxt = st_r;
    i_nxt  = i_r;
    d_nxt  = d_r;
    cmd    = '0;
    emit_v = 1'b0;
    emit_last = 1'b0;
    unique case (st_r)
      lsdr_pkg::ST_LOAD: begin
        if (start) begin
          cmd.load = 1'b1;
          if (final_item) st_nxt = lsdr_pkg::ST_CLR;
        end
      end
      lsdr_pkg::ST_CLR: begin
        // decide another pass, emit, or end an empty set
        i_nxt = '0;
        if (sts.more_pass) begin
          cmd.clr_cnt = 1'b1;
          st_nxt = lsdr_pkg::ST_COUNT;
        end else if (sts.empty) begin
          cmd.done_set = 1'b1;
          st_nxt = lsdr_pkg::ST_LOAD;
        end else begin
          st_nxt = lsdr_pkg::ST_EMIT;
        end
      end
      lsdr_pkg::ST_COUNT: begin
        cmd.count = 1'b1;
        i_nxt = i_r + CNT_W'(1);
        if (i_nxt == fill_cnt) st_nxt = lsdr_pkg::ST_PSUM;
      end
      lsdr_pkg::ST_PSUM: begin
        // nine running-sum steps over the digit counters
        cmd.psum = 1'b1;
        d_nxt = d_r + DW'(1);
        i_nxt = fill_cnt - CNT_W'(1);
        if (d_r == DW'(lsdr_pkg::RADIX - 2)) begin
          d_nxt = '0;
          st_nxt = lsdr_pkg::ST_PLACE;
        end
      end
      lsdr_pkg::ST_PLACE: begin
        cmd.place = 1'b1;
        i_nxt = i_r - CNT_W'(1);
        if (i_r == '0) begin
          i_nxt = '0;
          st_nxt = lsdr_pkg::ST_GAP;
        end
      end
      lsdr_pkg::ST_GAP: begin
        // last scatter write lands before the copy reads
        i_nxt = '0;
        st_nxt = lsdr_pkg::ST_COPY;
      end
      lsdr_pkg::ST_COPY: begin
        cmd.copy = 1'b1;
        i_nxt = i_r + CNT_W'(1);
        if (i_nxt == fill_cnt) begin
          cmd.next_w = 1'b1;
          st_nxt = lsdr_pkg::ST_CLR;
        end
      end
      lsdr_pkg::ST_EMIT: begin
        emit_v = 1'b1;
        i_nxt = i_r + CNT_W'(1);
        if (i_nxt == fill_cnt) begin
          emit_last = 1'b1;
          cmd.done_set = 1'b1;
          st_nxt = lsdr_pkg::ST_LOAD;
        end
      end
      default: st_nxt = lsdr_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= lsdr_pkg::ST_LOAD;
      i_r  <= '0;
      d_r  <= '0;
    end else begin
      st_r <= st_nxt;
      i_r  <= i_nxt;
      d_r  <= d_nxt;
    end
  end
endmodule

@@ src/lsd_radix_sort_base10.sv @@
// Loading: one word per cycle while busy is low. After the final word the sort
// runs p digit passes, p = decimal digits of the largest stored key (0 to 5),
// each made of the steps decide, count n, 9 running-sum steps, scatter n, one
// gap, copy n, for n stored records; then the words leave in order, one per
// cycle, and the receiver cannot stall.
// Reset (rst_n low, synchronous): empty set, controller back to loading.
module lsd_radix_sort_base10 #(
  parameter int MAX_RECORDS = lsdr_pkg::MAX_RECORDS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [lsdr_pkg::KEY_W-1:0]   in_key,
  input  logic [lsdr_pkg::TAG_W-1:0]   in_tag,
  input  logic                         in_final_item,
  output logic                         out_valid,
  output logic [lsdr_pkg::KEY_W-1:0]   out_sorted_key,
  output logic [lsdr_pkg::TAG_W-1:0]   out_sorted_tag,
  output logic                         out_final_result,
  output logic                         out_overflowed
);
  localparam int IDX_W = $clog2(MAX_RECORDS);
  localparam int CNT_W = $clog2(MAX_RECORDS + 1);

  lsdr_pkg::cmd_t cmd;
  lsdr_pkg::sts_t sts;
  logic [IDX_W-1:0] idx;
  logic [CNT_W-1:0] fill_cnt;
  logic dropped, emit_v, emit_last;
  logic [lsdr_pkg::KEY_W-1:0] rd_key;
  logic [lsdr_pkg::TAG_W-1:0] rd_tag;
  logic valid_r, last_r, ovf_r;

  lsdr_ctrl #(.MAX_RECORDS(MAX_RECORDS)) u_ctrl (
    .clk, .rst_n, .start, .final_item(in_final_item), .sts, .fill_cnt,
    .cmd, .idx, .busy, .emit_v, .emit_last
  );

  lsdr_datapath #(.MAX_RECORDS(MAX_RECORDS)) u_dp (
    .clk, .rst_n, .cmd, .idx, .in_key, .in_tag, .sts, .fill_cnt, .dropped,
    .rd_key, .rd_tag
  );

  // output flags, aligned with the registered record read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= emit_v;
    end
    last_r <= emit_last;
    ovf_r  <= dropped;
  end

  assign out_valid        = valid_r;
  assign out_sorted_key   = rd_key;
  assign out_sorted_tag   = rd_tag;
  assign out_final_result = last_r;
  assign out_overflowed   = ovf_r;

  // words are emitted only while busy is high
  a_busy_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit_v |-> busy) else $error("emit while idle");
  // last flag only on a valid word
  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_final_result |-> out_valid) else $error("last without valid");
  // after the last word the block returns to loading
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_final_result) |-> !busy) else $error("not idle after last");
endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import lsdr_pkg::*;

  localparam int CAPACITY = MAX_RECORDS_DEF;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             last;
    logic             ovf;
  } sorted_word_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic             fin;
    logic             typed;   // expected word typed in below
    logic [KEY_W-1:0] t_key;
    logic [TAG_W-1:0] t_tag;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [KEY_W-1:0] in_key = '0;
  logic [TAG_W-1:0] in_tag = '0;
  logic             in_final_item = 1'b0;
  logic             out_valid;
  logic [KEY_W-1:0] out_sorted_key;
  logic [TAG_W-1:0] out_sorted_tag;
  logic             out_final_result;
  logic             out_overflowed;

  // pending sorted words, oldest first
  sorted_word_t sorted_q[$];
  // records held by the predictor for the open set
  logic [KEY_W-1:0] held_key[CAPACITY];
  logic [TAG_W-1:0] held_tag[CAPACITY];
  int unsigned      held_cnt = 0;
  logic             held_drop = 1'b0;

  int unsigned errors = 0;
  int unsigned n_words = 0;
  int unsigned n_sets = 0;
  int unsigned n_ovf_sets = 0;
  int unsigned idle_pct = 0;

  lsd_radix_sort_base10 i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_key           (in_key),
    .in_tag           (in_tag),
    .in_final_item    (in_final_item),
    .out_valid        (out_valid),
    .out_sorted_key   (out_sorted_key),
    .out_sorted_tag   (out_sorted_tag),
    .out_final_result (out_final_result),
    .out_overflowed   (out_overflowed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // store a record; on the final one sort the set stably by key
  task automatic sort_record(input logic [KEY_W-1:0] k, input logic [TAG_W-1:0] t,
                             input logic fin);
    int unsigned order[$];
    int unsigned j;
    sorted_word_t w;
    if (held_cnt < CAPACITY) begin
      held_key[held_cnt] = k;
      held_tag[held_cnt] = t;
      held_cnt++;
    end else begin
      held_drop = 1'b1;
    end
    if (fin) begin
      // insertion keeps equal keys in arrival order
      for (int unsigned i = 0; i < held_cnt; i++) begin
        j = order.size();
        while (j > 0 && held_key[order[j-1]] > held_key[i]) j--;
        order.insert(j, i);
      end
      for (int unsigned i = 0; i < held_cnt; i++) begin
        w.key  = held_key[order[i]];
        w.tag  = held_tag[order[i]];
        w.last = (i + 1 == held_cnt);
        w.ovf  = held_drop;
        sorted_q.push_back(w);
      end
      n_sets++;
      if (held_drop) n_ovf_sets++;
      held_cnt  = 0;
      held_drop = 1'b0;
    end
  endtask

  // drive one word at the falling edge and hold it until accepted
  task automatic send_word(input logic [KEY_W-1:0] k, input logic [TAG_W-1:0] t,
                           input logic fin);
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start         = 1'b1;
    in_key        = k;
    in_tag        = t;
    in_final_item = fin;
    do @(posedge clk); while (busy);
  endtask

  task automatic drop_start();
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic wait_drained();
    drop_start();
    while (sorted_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [KEY_W-1:0] rand_key();
    case ($urandom_range(3))
      0:       return KEY_W'($urandom_range(9));
      1:       return KEY_W'($urandom_range(999));
      2:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      default: return KEY_W'($urandom());
    endcase
  endfunction

  // check each emitted word against the oldest expectation
  always @(posedge clk) begin
    sorted_word_t got;
    sorted_word_t want;
    if (rst_n && out_valid) begin
      got = {out_sorted_key, out_sorted_tag, out_final_result, out_overflowed};
      n_words++;
      if (sorted_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: key=%0d tag=%0d last=%b ovf=%b",
                   got.key, got.tag, got.last, got.ovf);
      end else begin
        want = sorted_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp key=%0d tag=%0d last=%b ovf=%b, got key=%0d tag=%0d last=%b ovf=%b",
                     want.key, want.tag, want.last, want.ovf,
                     got.key, got.tag, got.last, got.ovf);
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    stim_row_t rows[$];
    sorted_word_t w;
    int unsigned set_len;
    int unsigned sent;

    // directed: single-record extremes, zero-key sets, stability, spread keys
    rows = '{
      '{16'd0,     6'd0,  1'b1, 1'b1, 16'd0,     6'd0},
      '{16'hFFFF,  6'd63, 1'b1, 1'b1, 16'hFFFF,  6'd63},
      '{16'd0,     6'd5,  1'b0, 1'b0, 16'd0,     6'd0},
      '{16'd0,     6'd6,  1'b0, 1'b0, 16'd0,     6'd0},
      '{16'd0,     6'd7,  1'b1, 1'b0, 16'd0,     6'd0},
      '{16'hFFFF,  6'd1,  1'b0, 1'b0, 16'd0,     6'd0},
      '{16'd0,     6'd2,  1'b0, 1'b0, 16'd0,     6'd0},
      '{16'd12345, 6'd3,  1'b0, 1'b0, 16'd0,     6'd0},
      '{16'd9,     6'd4,  1'b0, 1'b0, 16'd0,     6'd0},
      '{16'd10,    6'd8,  1'b0, 1'b0, 16'd0,     6'd0},
      '{16'd12345, 6'd9,  1'b0, 1'b0, 16'd0,     6'd0},
      '{16'd0,     6'd10, 1'b1, 1'b0, 16'd0,     6'd0},
      '{16'd42,    6'd42, 1'b0, 1'b0, 16'd0,     6'd0},
      '{16'd42,    6'd21, 1'b0, 1'b0, 16'd0,     6'd0},
      '{16'd41,    6'd63, 1'b0, 1'b0, 16'd0,     6'd0},
      '{16'd42,    6'd0,  1'b1, 1'b0, 16'd0,     6'd0},
      '{16'd34463, 6'd11, 1'b1, 1'b1, 16'd34463, 6'd11}
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (rows[r]) begin
      if (rows[r].typed) begin
        w = {rows[r].t_key, rows[r].t_tag, 1'b1, 1'b0};
        sorted_q.push_back(w);
        n_sets++;
      end else begin
        sort_record(rows[r].key, rows[r].tag, rows[r].fin);
      end
      send_word(rows[r].key, rows[r].tag, rows[r].fin);
    end

    // hold off until the sorter has emitted everything
    wait_drained();

    // random sets in three idling phases; one set overfills the store
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 21 : (ph == 1) ? 86 : 0;
      sent = 0;
      while (sent < 12) begin
        set_len = (ph == 1 && sent == 0) ? CAPACITY + 2 :
                  ($urandom_range(7) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 8);
        for (int unsigned i = 0; i < set_len; i++) begin
          logic [KEY_W-1:0] k;
          logic [TAG_W-1:0] t;
          logic f;
          k = rand_key();
          t = TAG_W'($urandom());
          f = (i + 1 == set_len);
          sort_record(k, t, f);
          send_word(k, t, f);
        end
        sent += set_len;
      end
      wait_drained();
    end

    wait_drained();
    repeat (50) @(posedge clk);
    $display("covered %0d sorted sets (%0d with dropped records), %0d words out",
             n_sets, n_ovf_sets, n_words);
    if (errors == 0 && sorted_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
